// ===== design/bsp_pkg.sv =====
// Shared constants, types and helpers for the B-spline basis evaluator.
// No dependencies; imported by bsp_term, bspline_single_basis_eval and the testbench.
package bsp_pkg;

    localparam int MAX_DEGREE = 4;
    localparam int KNOT_COUNT = 6;
    // degree actually supported by the pipeline structure
    localparam int DEG_LIMIT  = (MAX_DEGREE < KNOT_COUNT - 2) ? MAX_DEGREE : KNOT_COUNT - 2;
    localparam int NV_COUNT   = DEG_LIMIT + 1;

    localparam int KNOT_W     = 32;
    localparam int QBITS      = 31;
    localparam int PROD_W     = QBITS + KNOT_W;
    // term latency: operand stage, multiply stage, one stage per quotient bit
    localparam int TERM_LAT   = QBITS + 2;

    localparam int DEG_W      = 3;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [KNOT_W-1:0] q16_t;
    typedef logic [QBITS-1:0]         q30_t;
    typedef logic [DEG_W-1:0]         deg_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam q30_t ONE_Q30 = q30_t'(1) << 30;

    // register indexes
    localparam cfg_idx_t REG_DEGREE = 3'd0;
    localparam cfg_idx_t REG_KNOT_0 = 3'd1;
    localparam cfg_idx_t REG_KNOT_1 = 3'd2;
    localparam cfg_idx_t REG_KNOT_2 = 3'd3;
    localparam cfg_idx_t REG_KNOT_3 = 3'd4;
    localparam cfg_idx_t REG_KNOT_4 = 3'd5;
    localparam cfg_idx_t REG_KNOT_5 = 3'd6;

    // one pipeline slot between triangle levels
    typedef struct packed {
        logic                 valid;
        logic                 ovr_one;
        logic                 ovr_out;
        q16_t                 u;
        q30_t [NV_COUNT-1:0]  nv;
    } stage_t;

    // sum of two terms, saturated at 1.0
    function automatic q30_t sat_sum(input q30_t a, input q30_t b);
        logic [QBITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_Q30}) ? ONE_Q30 : s[QBITS-1:0];
    endfunction

endpackage

// ===== design/bsp_term.sv =====
// One weighted term floor(val * num / den) with clamped num and den.
// Pipelined: operand stage, multiply stage, restoring divider one bit per stage.
// Depends on bsp_pkg.
module bsp_term (
    input  logic         clk,
    input  logic         en,
    input  bsp_pkg::q30_t val,
    input  bsp_pkg::q16_t x,
    input  bsp_pkg::q16_t y,
    input  bsp_pkg::q16_t z,
    input  bsp_pkg::q16_t w,
    output bsp_pkg::q30_t q
);
    import bsp_pkg::*;

    typedef struct packed {
        logic [KNOT_W-1:0] rem;
        logic [KNOT_W-1:0] den;
        logic [QBITS-1:0]  low;
        q30_t              quo;
    } div_t;

    // operand stage: num = x - y, den = z - w, clamp rules
    logic signed [KNOT_W:0] num_d;
    logic signed [KNOT_W:0] den_d;
    logic [KNOT_W-1:0]      num_c;
    logic [KNOT_W-1:0]      den_c;
    logic                   den_ok;
    logic                   num_ok;

    assign num_d  = (KNOT_W+1)'(x) - (KNOT_W+1)'(y);
    assign den_d  = (KNOT_W+1)'(z) - (KNOT_W+1)'(w);
    assign den_ok = den_d > 0;
    assign num_ok = num_d > 0;

    always_comb
    begin
        if (!den_ok || !num_ok)
            num_c = '0;
        else if (num_d > den_d)
            num_c = den_d[KNOT_W-1:0];
        else
            num_c = num_d[KNOT_W-1:0];
        // zero numerator with unit divisor gives a zero quotient
        den_c = den_ok ? den_d[KNOT_W-1:0] : KNOT_W'(1);
    end

    q30_t              val_reg;
    logic [KNOT_W-1:0] num_reg;
    logic [KNOT_W-1:0] den_s0_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [KNOT_W-1:0] den_s1_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = val_reg * num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg    <= val;
            num_reg    <= num_c;
            den_s0_reg <= den_c;
            prod_reg   <= prod_next;
            den_s1_reg <= den_s0_reg;
        end
    end

    // restoring divider, quotient bit QBITS-1-j in stage j
    div_t div_in [QBITS];
    div_t div_reg [QBITS];

    assign div_in[0] = '{rem: prod_reg[PROD_W-1 -: KNOT_W], den: den_s1_reg,
                         low: prod_reg[QBITS-1:0], quo: '0};

    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        localparam int B = QBITS - 1 - j;
        logic [KNOT_W:0] r2;
        logic [KNOT_W:0] diff;
        logic            ge;
        div_t            d_next;

        if (j > 0)
        begin : g_link
            assign div_in[j] = div_reg[j-1];
        end

        assign r2   = {div_in[j].rem, div_in[j].low[B]};
        assign diff = r2 - {1'b0, div_in[j].den};
        assign ge   = r2 >= {1'b0, div_in[j].den};

        always_comb
        begin
            d_next        = div_in[j];
            d_next.rem    = ge ? diff[KNOT_W-1:0] : r2[KNOT_W-1:0];
            d_next.quo[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[j] <= d_next;
        end
    end

    assign q = div_reg[QBITS-1].quo;

endmodule

// ===== design/bspline_single_basis_eval.sv =====
// Throughput: one point per cycle; every triangle term has its own multiply and
// a divider pipelined one quotient bit per stage, so the rate is set by nothing but stalls.
// An output stall while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, async low) clears all valid bits and loads degree 1 and knots 0..5.
module bspline_single_basis_eval (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bsp_pkg::cfg_idx_t    cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bsp_pkg::q16_t        param_u,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [30:0]          basis_value,
    output logic                 outside_support
);
    import bsp_pkg::*;

    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // configuration registers
    deg_t deg_reg;
    q16_t knot_reg [KNOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= DEG_W'(1);
            for (int i = 0; i < KNOT_COUNT; i++)
                knot_reg[i] <= KNOT_W'(i * 65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index) inside
                REG_DEGREE: deg_reg <= cfg_data[DEG_W-1:0];
                REG_KNOT_0, REG_KNOT_1, REG_KNOT_2, REG_KNOT_3, REG_KNOT_4, REG_KNOT_5:
                    knot_reg[cfg_index - REG_KNOT_0] <= cfg_data;
                default: ;
            endcase
        end
    end

    deg_t p_eff;
    assign p_eff = (deg_reg > DEG_W'(DEG_LIMIT)) ? DEG_W'(DEG_LIMIT) : deg_reg;

    // input register
    logic f0_valid_reg;
    q16_t f0_u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f0_valid_reg <= 1'b0;
        else if (en)
            f0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f0_u_reg <= param_u;
    end

    // end-knot multiplicity, support test and degree-0 values
    stage_t lvl_reg [DEG_LIMIT+1];
    stage_t f1_next;

    always_comb
    begin
        logic [3:0] run_f;
        logic [3:0] run_l;
        logic       go;
        q16_t       t_last;
        logic       full_f;
        logic       full_l;

        t_last = knot_reg[p_eff + DEG_W'(1)];

        run_f = 4'd1;
        go    = 1'b1;
        for (int i = 1; i < KNOT_COUNT; i++)
        begin
            if (i <= int'(p_eff) + 1)
            begin
                if (go && knot_reg[i] == knot_reg[0])
                    run_f = run_f + 4'd1;
                else
                    go = 1'b0;
            end
        end

        run_l = 4'd1;
        go    = 1'b1;
        for (int i = KNOT_COUNT - 2; i >= 0; i--)
        begin
            if (i <= int'(p_eff))
            begin
                if (go && knot_reg[i] == t_last)
                    run_l = run_l + 4'd1;
                else
                    go = 1'b0;
            end
        end

        full_f = run_f == (4'(p_eff) + 4'd1);
        full_l = run_l == (4'(p_eff) + 4'd1);

        f1_next.valid   = f0_valid_reg;
        f1_next.u       = f0_u_reg;
        f1_next.ovr_one = (f0_u_reg == knot_reg[0] && full_f) ||
                          (f0_u_reg == t_last && full_l);
        f1_next.ovr_out = (f0_u_reg < knot_reg[0]) || (f0_u_reg >= t_last);
        for (int i = 0; i < NV_COUNT; i++)
            f1_next.nv[i] = (i <= int'(p_eff) && f0_u_reg >= knot_reg[i] &&
                             f0_u_reg < knot_reg[i+1]) ? ONE_Q30 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lvl_reg[0] <= '0;
        else if (en)
            lvl_reg[0] <= f1_next;
    end

    // one triangle level per block
    for (genvar k = 1; k <= DEG_LIMIT; k++)
    begin : g_lvl
        localparam int NLANE = DEG_LIMIT + 1 - k;
        stage_t dly_reg [TERM_LAT];
        q30_t   q_l [NLANE];
        q30_t   q_r [NLANE];
        stage_t lvl_next;

        for (genvar i = 0; i < NLANE; i++)
        begin : g_lane
            bsp_term u_left (
                .clk (clk),
                .en  (en),
                .val (lvl_reg[k-1].nv[i]),
                .x   (lvl_reg[k-1].u),
                .y   (knot_reg[i]),
                .z   (knot_reg[i+k]),
                .w   (knot_reg[i]),
                .q   (q_l[i])
            );
            bsp_term u_right (
                .clk (clk),
                .en  (en),
                .val (lvl_reg[k-1].nv[i+1]),
                .x   (knot_reg[i+k+1]),
                .y   (lvl_reg[k-1].u),
                .z   (knot_reg[i+k+1]),
                .w   (knot_reg[i+1]),
                .q   (q_r[i])
            );
        end

        // side data travels alongside the term pipelines
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                for (int j = 0; j < TERM_LAT; j++)
                    dly_reg[j] <= '0;
            end
            else if (en)
            begin
                dly_reg[0] <= lvl_reg[k-1];
                for (int j = 1; j < TERM_LAT; j++)
                    dly_reg[j] <= dly_reg[j-1];
            end
        end

        // levels above the degree pass values through
        always_comb
        begin
            lvl_next = dly_reg[TERM_LAT-1];
            if (k <= int'(p_eff))
            begin
                for (int i = 0; i < NLANE; i++)
                    lvl_next.nv[i] = sat_sum(q_l[i], q_r[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lvl_reg[k] <= '0;
            else if (en)
                lvl_reg[k] <= lvl_next;
        end
    end

    // output register
    stage_t last;
    q30_t   val_next;
    logic   out_valid_reg;
    q30_t   basis_reg;
    logic   outside_reg;

    assign last = lvl_reg[DEG_LIMIT];

    always_comb
    begin
        if (last.ovr_one)
            val_next = ONE_Q30;
        else if (last.ovr_out)
            val_next = '0;
        else
            val_next = (last.nv[0] > ONE_Q30) ? ONE_Q30 : last.nv[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            basis_reg   <= val_next;
            outside_reg <= last.ovr_out && !last.ovr_one;
        end
    end

    assign out_valid       = out_valid_reg;
    assign basis_value     = basis_reg;
    assign outside_support = outside_reg;

`ifndef ASSERT_OFF
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outside_support) |-> (basis_value == '0))
        else $error("outside support with nonzero value");
    a_value_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (basis_value <= ONE_Q30))
        else $error("basis value above one");
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> f0_valid_reg)
        else $error("accepted point lost at input stage");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(lvl_reg[DEG_LIMIT]))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ===== sim/bspline_single_basis_eval_tb.sv =====
// Self-checking testbench for bspline_single_basis_eval: drives parameter points and knot setups,
// predicts each basis value and compares it with the block's output.
// Depends on bsp_pkg and the bspline_single_basis_eval RTL.
`timescale 1ns / 100ps

module bspline_single_basis_eval_tb;
    import bsp_pkg::*;

    localparam int  DRAIN_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint ONE = 64'd1 << 30;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    cfg_idx_t      cfg_index = REG_DEGREE;
    logic [31:0]   cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    q16_t          param_u = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [30:0]   basis_value;
    logic          outside_support;

    typedef struct packed {
        logic [30:0] value;
        logic        outside;
    } basis_res_t;

    // shadow copy of the configuration registers
    logic [2:0]    sh_degree;
    longint        sh_knot [KNOT_COUNT];

    q16_t          point_q [$];
    basis_res_t    basis_exp_q [$];
    int            err_count = 0;
    int            n_points = 0;
    int            n_results = 0;
    int            n_ones = 0;
    int            n_outside = 0;
    longint        cycle_count = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            hold_cycles = 0;
    bit            hold_request = 1'b0;
    bit            in_taken = 1'b0;

    bspline_single_basis_eval u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .param_u         (param_u),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .basis_value     (basis_value),
        .outside_support (outside_support)
    );

    always #5 clk = ~clk;

    // floor(val * num / den), zero for degenerate spans, numerator clipped to span
    function automatic longint weigh_term(longint val, longint num, longint den);
        if (val == 0 || den <= 0 || num <= 0)
            return 0;
        if (num > den)
            num = den;
        return (val * num) / den;
    endfunction

    function automatic basis_res_t basis_at(q16_t u_in);
        basis_res_t r;
        longint nv [KNOT_COUNT];
        longint u;
        longint s;
        int p;
        int run;
        u = longint'(u_in);
        p = int'(sh_degree);
        if (p > DEG_LIMIT)
            p = DEG_LIMIT;
        r.value = '0;
        r.outside = 1'b0;
        // full multiplicity at the first knot
        run = 1;
        for (int i = 1; i <= p + 1 && sh_knot[i] == sh_knot[0]; i++)
            run++;
        if (u == sh_knot[0] && run == p + 1)
        begin
            r.value = 31'(ONE);
            return r;
        end
        // full multiplicity at the last knot
        run = 1;
        for (int i = p; i >= 0 && sh_knot[i] == sh_knot[p+1]; i--)
            run++;
        if (u == sh_knot[p+1] && run == p + 1)
        begin
            r.value = 31'(ONE);
            return r;
        end
        if (u < sh_knot[0] || u >= sh_knot[p+1])
        begin
            r.outside = 1'b1;
            return r;
        end
        for (int i = 0; i <= p; i++)
            nv[i] = (u >= sh_knot[i] && u < sh_knot[i+1]) ? ONE : 0;
        // triangle levels
        for (int k = 1; k <= p; k++)
            for (int i = 0; i <= p - k; i++)
            begin
                s = weigh_term(nv[i], u - sh_knot[i], sh_knot[i+k] - sh_knot[i])
                  + weigh_term(nv[i+1], sh_knot[i+k+1] - u, sh_knot[i+k+1] - sh_knot[i+1]);
                nv[i] = (s > ONE) ? ONE : s;
            end
        r.value = 31'((nv[0] > ONE) ? ONE : nv[0]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_count++;
        $display("MISMATCH %s at result %0d: got %0d expected %0d", what, n_results, got, want);
    endtask

    // append one point to the pending queue
    task automatic add_point(input q16_t v);
        point_q = {point_q, v};
    endtask

    // input transfer seen at the rising edge
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
    end

    // input driver: one transfer per accepted point, random gaps between points
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                in_taken = 1'b0;
                basis_exp_q = {basis_exp_q, basis_at(param_u)};
                n_points++;
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
            end
            else if (!in_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (point_q.size() > 0)
                begin
                    param_u <= point_q.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // receiver stall: random per result, plus a long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && hold_cycles == 0)
            begin
                hold_cycles = 400;
                hold_request = 1'b0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        basis_res_t want;
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (basis_exp_q.size() == 0)
                report_mismatch("unexpected transfer", basis_value, 0);
            else
            begin
                want = basis_exp_q.pop_front();
                if (basis_value !== want.value)
                    report_mismatch("basis_value", basis_value, want.value);
                if (outside_support !== want.outside)
                    report_mismatch("outside_support", outside_support, want.outside);
                if (want.outside)
                    n_outside++;
                if (want.value == 31'(ONE))
                    n_ones++;
            end
            n_results++;
            recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bspline_single_basis_eval_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_DEGREE)
            sh_degree = data[2:0];
        else
            sh_knot[int'(idx) - 1] = longint'($signed(data));
    endtask

    task automatic load_setup(input logic [2:0] deg, input longint k [KNOT_COUNT]);
        write_reg(REG_DEGREE, 32'(deg));
        write_reg(REG_KNOT_0, 32'(k[0]));
        write_reg(REG_KNOT_1, 32'(k[1]));
        write_reg(REG_KNOT_2, 32'(k[2]));
        write_reg(REG_KNOT_3, 32'(k[3]));
        write_reg(REG_KNOT_4, 32'(k[4]));
        write_reg(REG_KNOT_5, 32'(k[5]));
    endtask

    // wait until every point is sent and answered, then let the pipe settle
    task automatic drain;
        while (point_q.size() > 0 || in_valid || basis_exp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random nondecreasing knots, sometimes with repeats, at a chosen scale
    task automatic random_knots(output longint k [KNOT_COUNT]);
        longint step_max;
        case ($urandom_range(0, 3))
            0: step_max = 8;
            1: step_max = 65536;
            2: step_max = 64'd1 << 22;
            default: step_max = 64'd1 << 28;
        endcase
        k[0] = longint'($signed($urandom)) >>> $urandom_range(1, 8);
        for (int i = 1; i < KNOT_COUNT; i++)
        begin
            k[i] = k[i-1];
            if ($urandom_range(0, 3) != 0)
                k[i] += $urandom_range(1, int'(step_max));
            if (k[i] > 64'sd2147483647)
                k[i] = 64'sd2147483647;
        end
    endtask

    // points spread over the support with hits on the knots and some outside
    task automatic queue_points(input int count);
        int p;
        longint lo;
        longint hi;
        longint v;
        p = (int'(sh_degree) > DEG_LIMIT) ? DEG_LIMIT : int'(sh_degree);
        lo = sh_knot[0];
        hi = sh_knot[p+1];
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0: v = sh_knot[$urandom_range(0, p + 1)];
                1: v = longint'($signed($urandom));
                2: v = sh_knot[$urandom_range(0, p + 1)] + $urandom_range(0, 2) - 1;
                default: v = (hi > lo) ? lo + (longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff)
                                           % (hi - lo) : lo;
            endcase
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            add_point(q16_t'(v));
        end
    endtask

    initial
    begin
        longint kn [KNOT_COUNT];
        sh_degree = 3'd1;
        for (int i = 0; i < KNOT_COUNT; i++)
            sh_knot[i] = i * 65536;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setup: extremes of u, knot hits, midpoints
        add_point(32'sh8000_0000);
        add_point(32'sh7fff_ffff);
        add_point(32'sh0000_0000);
        add_point(32'sh0000_8000);
        add_point(32'sh0001_0000);
        add_point(32'sh0001_8000);
        add_point(32'sh0002_0000);
        add_point(32'sh0000_0001);
        add_point(32'shffff_ffff);
        add_point(32'sh5555_aaaa);
        add_point(32'shaaaa_5555);
        drain();

        // clamped degree-4 ends: full multiplicity at the first end, then at the last end
        kn = '{0, 0, 0, 0, 0, 65536};
        load_setup(3'd4, kn);
        add_point(32'sh0000_0000);
        add_point(32'sh0000_4000);
        add_point(32'sh0001_0000);
        add_point(32'shffff_ffff);
        kn = '{0, 65536, 65536, 65536, 65536, 65536};
        drain();
        load_setup(3'd4, kn);
        add_point(32'sh0001_0000);
        add_point(32'sh0000_c000);
        drain();

        // degree above the limit, degree 0, and decreasing knots
        kn = '{-64'sd2147483648, -1000, 0, 1000, 64'sd2147483647, 64'sd2147483647};
        load_setup(3'd7, kn);
        queue_points(8);
        drain();
        kn = '{100, 50, 20, 200, 10, 5};
        load_setup(3'd0, kn);
        queue_points(4);
        drain();
        load_setup(3'd3, kn);
        queue_points(6);
        drain();

        // random phases across degrees and knot spacings
        for (int ph = 0; ph < 24; ph++)
        begin
            random_knots(kn);
            load_setup(3'($urandom_range(0, 7)), kn);
            queue_points(60);
            if (ph == 5)
                hold_request = 1'b1;
            drain();
        end

        $display("covered %0d points over degrees 0..7, the reset knots and 29 loaded setups",
                 n_points);
        $display("%0d results checked, %0d at full value, %0d outside support",
                 n_results, n_ones, n_outside);
        if (err_count == 0)
            $display("bspline_single_basis_eval_tb OK");
        else
            $display("bspline_single_basis_eval_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bsp_pkg.sv
design/bsp_term.sv
design/bspline_single_basis_eval.sv
sim/bspline_single_basis_eval_tb.sv
